// File: rtl/core/multichannel_biquad_filter_defines.svh
// Assertion macros for the multichannel biquad filter checker.
// Included by the checker file; no other dependencies.
`ifndef MULTICHANNEL_BIQUAD_FILTER_DEFINES_SVH
`define MULTICHANNEL_BIQUAD_FILTER_DEFINES_SVH

// Checked on every rising edge of clk while arst_n is high.
`define MBQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define MBQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/mbq_pkg.sv
// Shared constants, register codes, types and helpers for the biquad filter.
// Used by the interfaces, the datapath and the top level.
package mbq_pkg;

	localparam int MAX_CHANNELS   = 8;
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 26;

	localparam int COEF_W  = 32;
	localparam int OUT_W   = 32;
	localparam int LIMIT_W = 31;
	localparam int COUNT_W = 4;
	localparam int CHIDX_W = 3;
	localparam int DATA_W  = 32;
	localparam int INDEX_W = 3;
	localparam int MAG_W   = 33;

	typedef enum logic [INDEX_W-1:0] {
		REG_B0    = 3'd0,
		REG_B1    = 3'd1,
		REG_B2    = 3'd2,
		REG_A1    = 3'd3,
		REG_A2    = 3'd4,
		REG_COUNT = 3'd5,
		REG_LIMIT = 3'd6
	} reg_index_t;

	localparam logic signed [COEF_W-1:0] RESET_B0    = 32'sd67108864;
	localparam logic signed [COEF_W-1:0] RESET_COEF  = 32'sd0;
	localparam logic [COUNT_W-1:0]       RESET_COUNT = 4'd2;
	localparam logic [LIMIT_W-1:0]       RESET_LIMIT = 31'h7fffffff;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic [LIMIT_W-1:0]       limit;
	} filter_cfg_t;

	function automatic logic [MAG_W-1:0] magnitude(input logic signed [MAG_W-1:0] v);
		return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

endpackage

// File: rtl/core/mbq_if.sv
// Valid/ready stream interfaces for the sample input and the result output.
// Depends on mbq_pkg for default widths.
interface mbq_in_if #(
	parameter int SAMPLE_BITS = mbq_pkg::SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface mbq_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [mbq_pkg::OUT_W-1:0]   filtered;
	logic [mbq_pkg::CHIDX_W-1:0]        channel_index;
	logic                               history_cleared;

	modport source(output valid, output filtered, output channel_index,
		output history_cleared, input ready);
	modport sink(input valid, input filtered, input channel_index,
		input history_cleared, output ready);
endinterface

// File: rtl/core/mbq_datapath.sv
// Per-channel history storage and the single-pass multiply-accumulate, round and limit check.
// Depends on mbq_pkg for the configuration struct and the magnitude helper.
module mbq_datapath #(
	parameter int MAX_CHANNELS   = mbq_pkg::MAX_CHANNELS,
	parameter int SAMPLE_BITS    = mbq_pkg::SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = mbq_pkg::COEF_FRAC_BITS,
	localparam int CH_W          = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic [CH_W-1:0]                   ch,
	input  mbq_pkg::filter_cfg_t              cfg,
	output logic signed [mbq_pkg::OUT_W-1:0]  filtered,
	output logic                              cleared
);

	localparam int OUT_W = mbq_pkg::OUT_W;
	localparam int MAG_W = mbq_pkg::MAG_W;
	localparam int PX_W  = mbq_pkg::COEF_W + SAMPLE_BITS;
	localparam int PY_W  = mbq_pkg::COEF_W + OUT_W;
	localparam int ACC_W = PY_W + 4;
	localparam int YW    = ACC_W - COEF_FRAC_BITS;
	localparam logic signed [ACC_W-1:0] ROUND =
		$signed({{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}});

	logic signed [SAMPLE_BITS-1:0] xh1_q [MAX_CHANNELS];
	logic signed [SAMPLE_BITS-1:0] xh2_q [MAX_CHANNELS];
	logic signed [OUT_W-1:0]       yh1_q [MAX_CHANNELS];
	logic signed [OUT_W-1:0]       yh2_q [MAX_CHANNELS];

	logic signed [SAMPLE_BITS-1:0] x1, x2;
	logic signed [OUT_W-1:0]       y1, y2, y0;
	logic signed [PX_W-1:0]        p0, p1, p2;
	logic signed [PY_W-1:0]        p3, p4;
	logic signed [ACC_W-1:0]       acc;
	logic [YW-1:0]                 y0w;
	logic                          fits;
	logic [MAG_W-1:0]              lim;
	logic                          bad;

	assign x1 = xh1_q[ch];
	assign x2 = xh2_q[ch];
	assign y1 = yh1_q[ch];
	assign y2 = yh2_q[ch];

	assign p0 = $signed(cfg.b0) * sample;
	assign p1 = $signed(cfg.b1) * x1;
	assign p2 = $signed(cfg.b2) * x2;
	assign p3 = $signed(cfg.a1) * y1;
	assign p4 = $signed(cfg.a2) * y2;

	assign acc = $signed({{(ACC_W-PX_W){p0[PX_W-1]}}, p0})
		+ $signed({{(ACC_W-PX_W){p1[PX_W-1]}}, p1})
		+ $signed({{(ACC_W-PX_W){p2[PX_W-1]}}, p2})
		- $signed({{(ACC_W-PY_W){p3[PY_W-1]}}, p3})
		- $signed({{(ACC_W-PY_W){p4[PY_W-1]}}, p4})
		+ ROUND;

	assign y0w  = acc[ACC_W-1:COEF_FRAC_BITS];
	assign fits = (y0w[YW-1:OUT_W-1] == '0) || (y0w[YW-1:OUT_W-1] == '1);
	assign y0   = $signed(y0w[OUT_W-1:0]);
	assign lim  = {2'b00, cfg.limit};

	assign bad = !fits
		|| (mbq_pkg::magnitude($signed({y0[OUT_W-1], y0})) > lim)
		|| (mbq_pkg::magnitude($signed({{(MAG_W-SAMPLE_BITS){x1[SAMPLE_BITS-1]}}, x1})) > lim)
		|| (mbq_pkg::magnitude($signed({{(MAG_W-SAMPLE_BITS){x2[SAMPLE_BITS-1]}}, x2})) > lim)
		|| (mbq_pkg::magnitude($signed({y1[OUT_W-1], y1})) > lim)
		|| (mbq_pkg::magnitude($signed({y2[OUT_W-1], y2})) > lim);

	assign filtered = bad ? '0 : y0;
	assign cleared  = bad;

	// A cleared channel keeps only the current sample as its newest input.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				xh1_q[i] <= '0;
				xh2_q[i] <= '0;
				yh1_q[i] <= '0;
				yh2_q[i] <= '0;
			end
		end else if (step) begin
			xh1_q[ch] <= sample;
			xh2_q[ch] <= bad ? '0 : x1;
			yh1_q[ch] <= bad ? '0 : y0;
			yh2_q[ch] <= bad ? '0 : y1;
		end
	end

endmodule

// File: rtl/core/multichannel_biquad_filter.sv
// Each sample is registered into stage one, then its result into the output stage once free.
// Throughput: one sample per cycle while the output is not stalled, set by the single stage
// holding five parallel multipliers, the sum, rounding and limit check, which writes the
// channel history in the same cycle the result is registered.
// Reset clears all channel history, the channel pointer, the pipeline valids and
// returns every configuration register to its reset value.
module multichannel_biquad_filter #(
	parameter int MAX_CHANNELS   = mbq_pkg::MAX_CHANNELS,
	parameter int SAMPLE_BITS    = mbq_pkg::SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = mbq_pkg::COEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mbq_in_if.sink                        samples,
	mbq_out_if.source                     results,
	input  logic                          wr_en,
	input  logic [mbq_pkg::INDEX_W-1:0]   wr_index,
	input  logic [mbq_pkg::DATA_W-1:0]    wr_data
);

	localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W   = ($clog2(MAX_CHANNELS + 1) > mbq_pkg::COUNT_W) ?
		$clog2(MAX_CHANNELS + 1) : mbq_pkg::COUNT_W;
	localparam int COUNT_W = mbq_pkg::COUNT_W;
	localparam int LIMIT_W = mbq_pkg::LIMIT_W;
	localparam int OUT_W   = mbq_pkg::OUT_W;
	localparam int CHIDX_W = mbq_pkg::CHIDX_W;

	mbq_pkg::filter_cfg_t cfg_q;
	logic [COUNT_W-1:0]   count_q;
	logic [CH_W-1:0]      pointer_q;

	logic [CNT_W-1:0] count_raw, count_eff, ch_next_wide;
	logic [CH_W-1:0]  ch_now;

	logic                          valid_s1, valid_s2;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [CH_W-1:0]               ch_s1;
	logic signed [OUT_W-1:0]       filtered_s2;
	logic [CHIDX_W-1:0]            chidx_s2;
	logic                          cleared_s2;

	logic                    accept, load_s2, advance;
	logic signed [OUT_W-1:0] filtered_d;
	logic                    cleared_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.b0    <= mbq_pkg::RESET_B0;
			cfg_q.b1    <= mbq_pkg::RESET_COEF;
			cfg_q.b2    <= mbq_pkg::RESET_COEF;
			cfg_q.a1    <= mbq_pkg::RESET_COEF;
			cfg_q.a2    <= mbq_pkg::RESET_COEF;
			cfg_q.limit <= mbq_pkg::RESET_LIMIT;
			count_q     <= mbq_pkg::RESET_COUNT;
		end else if (wr_en) begin
			case (mbq_pkg::reg_index_t'(wr_index))
				mbq_pkg::REG_B0: begin
					cfg_q.b0 <= $signed(wr_data);
				end
				mbq_pkg::REG_B1: begin
					cfg_q.b1 <= $signed(wr_data);
				end
				mbq_pkg::REG_B2: begin
					cfg_q.b2 <= $signed(wr_data);
				end
				mbq_pkg::REG_A1: begin
					cfg_q.a1 <= $signed(wr_data);
				end
				mbq_pkg::REG_A2: begin
					cfg_q.a2 <= $signed(wr_data);
				end
				mbq_pkg::REG_COUNT: begin
					count_q <= wr_data[COUNT_W-1:0];
				end
				mbq_pkg::REG_LIMIT: begin
					cfg_q.limit <= wr_data[LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// A zero count means one channel; a pointer past a lowered count restarts at channel zero.
	always_comb begin
		count_raw = CNT_W'(count_q);
		if (count_raw == '0) begin
			count_eff = CNT_W'(1);
		end else if (count_raw > CNT_W'(MAX_CHANNELS)) begin
			count_eff = CNT_W'(MAX_CHANNELS);
		end else begin
			count_eff = count_raw;
		end
		ch_now       = (CNT_W'(pointer_q) >= count_eff) ? '0 : pointer_q;
		ch_next_wide = CNT_W'(ch_now) + CNT_W'(1);
		if (ch_next_wide >= count_eff) begin
			ch_next_wide = '0;
		end
	end

	assign load_s2       = !valid_s2 || results.ready;
	assign advance       = valid_s1 && load_s2;
	assign samples.ready = !valid_s1 || load_s2;
	assign accept        = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_q <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			if (accept) begin
				pointer_q <= ch_next_wide[CH_W-1:0];
				valid_s1  <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= samples.sample;
			ch_s1     <= ch_now;
		end
		if (advance) begin
			filtered_s2 <= filtered_d;
			chidx_s2    <= CHIDX_W'(ch_s1);
			cleared_s2  <= cleared_d;
		end
	end

	mbq_datapath #(
		.MAX_CHANNELS  (MAX_CHANNELS),
		.SAMPLE_BITS   (SAMPLE_BITS),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.sample  (sample_s1),
		.ch      (ch_s1),
		.cfg     (cfg_q),
		.filtered(filtered_d),
		.cleared (cleared_d)
	);

	assign results.valid           = valid_s2;
	assign results.filtered        = filtered_s2;
	assign results.channel_index   = chidx_s2;
	assign results.history_cleared = cleared_s2;

endmodule

// File: rtl/core/mbq_checker.sv
// Port-level assertions for the multichannel biquad filter, bound to its top level.
// Depends on mbq_pkg and the assertion macros header.
`include "multichannel_biquad_filter_defines.svh"

module mbq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [mbq_pkg::OUT_W-1:0]    out_filtered,
	input logic                         out_cleared
);

	`MBQ_ASSERT_ALWAYS(a_reset_no_result, !arst_n |-> !out_valid, "result valid during reset")
	`MBQ_ASSERT(a_cleared_zero, out_valid && out_cleared |-> out_filtered == '0, "cleared result not zero")
	`MBQ_ASSERT(a_ready_follows, out_ready |-> in_ready, "input stalled while output drains")
	`MBQ_ASSERT(a_latency, in_valid && in_ready && !out_valid |=> ##1 out_valid, "result late")
	`MBQ_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_filtered), "stalled result changed")

endmodule

bind multichannel_biquad_filter mbq_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_filtered(results.filtered),
	.out_cleared (results.history_cleared)
);
